// File: rtl/alid_pkg.sv
// ----------------------------------------------------------------------------
// alid_pkg
// Shared types, codes and the microcode ROM for the array list unit.
// ----------------------------------------------------------------------------
package alid_pkg;

    localparam int ALID_CAPACITY = 128;

    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND       = 3'd0,
        CMD_INSERT_AT    = 3'd1,
        CMD_REMOVE_AT    = 3'd2,
        CMD_REMOVE_FIRST = 3'd3,
        CMD_REMOVE_LAST  = 3'd4,
        CMD_READ_AT      = 3'd5,
        CMD_READ_FIRST   = 3'd6,
        CMD_READ_LAST    = 3'd7
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // microcode program counter
    typedef enum logic [3:0] {
        STEP_IDLE      = 4'd0,
        STEP_INS_PRIME = 4'd1,
        STEP_INS_LOOP  = 4'd2,
        STEP_INS_PUT   = 4'd3,
        STEP_RM_PRIME  = 4'd4,
        STEP_RM_CAPT   = 4'd5,
        STEP_RM_LOOP   = 4'd6,
        STEP_RM_DONE   = 4'd7,
        STEP_RD_PRIME  = 4'd8,
        STEP_RD_CAPT   = 4'd9,
        STEP_EMIT      = 4'd10
    } step_t;

    // read address is relative to the next pointer value
    typedef enum logic [1:0] {
        RD_PTR = 2'd0,
        RD_DN  = 2'd1,
        RD_UP  = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_SHIFT = 2'd1,
        WR_NEW   = 2'd2
    } wr_sel_t;

    typedef enum logic [1:0] {
        PTR_HOLD = 2'd0,
        PTR_INC  = 2'd1,
        PTR_DEC  = 2'd2
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } cnt_op_t;

    // a taken condition jumps and suppresses the step's datapath ops
    typedef enum logic [2:0] {
        COND_NONE       = 3'd0,
        COND_DISPATCH   = 3'd1,
        COND_PTR_EQ_POS = 3'd2,
        COND_PTR_LAST   = 3'd3,
        COND_OUT_BUSY   = 3'd4
    } cond_t;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        ptr_op_t ptr_op;
        cnt_op_t cnt_op;
        logic    cap;
        logic    load_new;
        logic    emit;
        cond_t   cond;
        step_t   jump;
        step_t   next;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic ptr_eq_pos;
        logic ptr_last;
        logic out_busy;
    } alid_flags_t;

    typedef struct packed {
        ctrl_word_t cw;
        logic       run;
    } seq_out_t;

    function automatic ctrl_word_t ucode(step_t s);
        ctrl_word_t w;
        w.accept   = 1'b0;
        w.rd_en    = 1'b0;
        w.rd_sel   = RD_PTR;
        w.wr_sel   = WR_NONE;
        w.ptr_op   = PTR_HOLD;
        w.cnt_op   = CNT_HOLD;
        w.cap      = 1'b0;
        w.load_new = 1'b0;
        w.emit     = 1'b0;
        w.cond     = COND_NONE;
        w.jump     = STEP_IDLE;
        w.next     = STEP_IDLE;
        case (s)
            STEP_IDLE:
            begin
                w.accept = 1'b1;
                w.cond   = COND_DISPATCH;
                w.next   = STEP_IDLE;
            end
            STEP_INS_PRIME:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RD_DN;
                w.next   = STEP_INS_LOOP;
            end
            STEP_INS_LOOP:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RD_DN;
                w.wr_sel = WR_SHIFT;
                w.ptr_op = PTR_DEC;
                w.cond   = COND_PTR_EQ_POS;
                w.jump   = STEP_INS_PUT;
                w.next   = STEP_INS_LOOP;
            end
            STEP_INS_PUT:
            begin
                w.wr_sel   = WR_NEW;
                w.cnt_op   = CNT_INC;
                w.load_new = 1'b1;
                w.next     = STEP_EMIT;
            end
            STEP_RM_PRIME:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RD_PTR;
                w.next   = STEP_RM_CAPT;
            end
            STEP_RM_CAPT:
            begin
                w.cap    = 1'b1;
                w.rd_en  = 1'b1;
                w.rd_sel = RD_UP;
                w.next   = STEP_RM_LOOP;
            end
            STEP_RM_LOOP:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RD_UP;
                w.wr_sel = WR_SHIFT;
                w.ptr_op = PTR_INC;
                w.cond   = COND_PTR_LAST;
                w.jump   = STEP_RM_DONE;
                w.next   = STEP_RM_LOOP;
            end
            STEP_RM_DONE:
            begin
                w.cnt_op = CNT_DEC;
                w.next   = STEP_EMIT;
            end
            STEP_RD_PRIME:
            begin
                w.rd_en  = 1'b1;
                w.rd_sel = RD_PTR;
                w.next   = STEP_RD_CAPT;
            end
            STEP_RD_CAPT:
            begin
                w.cap  = 1'b1;
                w.next = STEP_EMIT;
            end
            STEP_EMIT:
            begin
                w.emit = 1'b1;
                w.cond = COND_OUT_BUSY;
                w.jump = STEP_EMIT;
                w.next = STEP_IDLE;
            end
            default:
            begin
                w.next = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/alid_if.sv
// ----------------------------------------------------------------------------
// alid_if
// Valid/ready channels: command words in, response words out.
// ----------------------------------------------------------------------------
interface alid_cmd_if;
    import alid_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, command, position, value, input ready);
    modport sink   (input valid, command, position, value, output ready);
endinterface

interface alid_rsp_if;
    import alid_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] result_value;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;

    modport source (output valid, result_value, status, count, input ready);
    modport sink   (input valid, result_value, status, count, output ready);
endinterface

// File: rtl/array_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete_unit
// Positional list of signed 32-bit words in a single-port-write RAM, driven
// by a microcoded sequencer. One response word per command word.
// ----------------------------------------------------------------------------
// Throughput: one command at a time; the shift loop moves one entry per
//   cycle through the RAM (one read and one write port).
// Reset: entry count and handshake state clear at once; RAM contents are left
//   as they are, no clearing pass.
module array_list_insert_delete_unit
    import alid_pkg::*;
#(
    parameter int CAPACITY = ALID_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    alid_cmd_if.sink    cmd,
    alid_rsp_if.source  rsp
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    seq_out_t    ctl;
    ctrl_word_t  cw;
    logic        run;
    alid_flags_t flags;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic signed [VALUE_W-1:0] hold_reg, hold_next;
    logic signed [VALUE_W-1:0] res_reg, res_next;
    status_t       st_reg, st_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    status_t                   out_status_reg, out_status_next;
    logic [COUNT_W-1:0]        out_count_reg, out_count_next;

    logic signed [VALUE_W-1:0] mem [CAPACITY];
    logic signed [VALUE_W-1:0] rdata_reg;
    logic [AW-1:0]             rd_addr;
    logic                      mem_rd;
    logic                      mem_wr;
    logic signed [VALUE_W-1:0] wr_data;

    logic          in_take;
    logic          emit_en;
    step_t         dec_step;
    status_t       dec_status;
    logic [AW-1:0] dec_ptr;
    logic [AW-1:0] dec_pos;
    logic [CMPW-1:0] posx;
    logic [CMPW-1:0] cntx;
    logic            full;
    logic [CW-1:0]   cnt_m1;

    alid_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .flags         (flags),
        .dispatch_step (dec_step),
        .ctl           (ctl)
    );

    assign cw  = ctl.cw;
    assign run = ctl.run;

    assign cmd.ready = cw.accept;
    assign in_take   = cmd.valid && cmd.ready;
    assign emit_en   = run && cw.emit;

    assign flags.in_valid   = cmd.valid;
    assign flags.ptr_eq_pos = (ptr_reg == pos_reg);
    assign flags.ptr_last   = ((CW'(ptr_reg) + CW'(1)) == count_reg);
    assign flags.out_busy   = out_valid_reg && !rsp.ready;

    // command decode and range checks
    assign posx   = CMPW'(cmd.position);
    assign cntx   = CMPW'(count_reg);
    assign full   = (count_reg >= CW'(CAPACITY));
    assign cnt_m1 = count_reg - CW'(1);

    always_comb
    begin
        dec_step   = STEP_EMIT;
        dec_status = ST_OK;
        dec_ptr    = AW'(cmd.position);
        dec_pos    = AW'(cmd.position);
        case (cmd_t'(cmd.command))
            CMD_APPEND:
            begin
                dec_ptr = AW'(count_reg);
                dec_pos = AW'(count_reg);
                if (full)
                    dec_status = ST_FULL;
                else
                    dec_step = STEP_INS_PRIME;
            end
            CMD_INSERT_AT:
            begin
                dec_ptr = AW'(count_reg);
                if (full)
                    dec_status = ST_FULL;
                else if (posx > cntx)
                    dec_status = ST_BADPOS;
                else
                    dec_step = STEP_INS_PRIME;
            end
            CMD_REMOVE_AT:
            begin
                if (posx >= cntx)
                    dec_status = ST_BADPOS;
                else
                    dec_step = STEP_RM_PRIME;
            end
            CMD_REMOVE_FIRST, CMD_REMOVE_LAST:
            begin
                dec_ptr = (cmd_t'(cmd.command) == CMD_REMOVE_FIRST) ? '0 : AW'(cnt_m1);
                if (count_reg == '0)
                    dec_status = ST_EMPTY;
                else
                    dec_step = STEP_RM_PRIME;
            end
            CMD_READ_AT:
            begin
                if (posx >= cntx)
                    dec_status = ST_BADPOS;
                else
                    dec_step = STEP_RD_PRIME;
            end
            CMD_READ_FIRST, CMD_READ_LAST:
            begin
                dec_ptr = (cmd_t'(cmd.command) == CMD_READ_FIRST) ? '0 : AW'(cnt_m1);
                if (count_reg == '0)
                    dec_status = ST_EMPTY;
                else
                    dec_step = STEP_RD_PRIME;
            end
            default:
            begin
                dec_status = ST_BADPOS;
            end
        endcase
    end

    // pointer and RAM addressing
    always_comb
    begin
        ptr_next = ptr_reg;
        if (in_take)
            ptr_next = dec_ptr;
        else if (run)
        begin
            case (cw.ptr_op)
                PTR_INC: ptr_next = ptr_reg + AW'(1);
                PTR_DEC: ptr_next = ptr_reg - AW'(1);
                default: ptr_next = ptr_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cw.rd_sel)
            RD_DN:   rd_addr = ptr_next - AW'(1);
            RD_UP:   rd_addr = ptr_next + AW'(1);
            default: rd_addr = ptr_next;
        endcase
    end

    assign mem_rd  = run && cw.rd_en;
    assign mem_wr  = run && (cw.wr_sel != WR_NONE);
    assign wr_data = (cw.wr_sel == WR_SHIFT) ? rdata_reg : hold_reg;

    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[ptr_reg] <= wr_data;
        if (mem_rd)
            rdata_reg <= mem[rd_addr];
    end

    // datapath next values
    always_comb
    begin
        pos_next  = in_take ? dec_pos : pos_reg;
        hold_next = in_take ? cmd.value : hold_reg;
        st_next   = in_take ? dec_status : st_reg;

        res_next = res_reg;
        if (in_take)
            res_next = '0;
        else if (run && cw.cap)
            res_next = rdata_reg;
        else if (run && cw.load_new)
            res_next = hold_reg;

        count_next = count_reg;
        if (run)
        begin
            case (cw.cnt_op)
                CNT_INC: count_next = count_reg + CW'(1);
                CNT_DEC: count_next = count_reg - CW'(1);
                default: count_next = count_reg;
            endcase
        end

        out_value_next  = emit_en ? res_reg : out_value_reg;
        out_status_next = emit_en ? st_reg : out_status_reg;
        out_count_next  = emit_en ? COUNT_W'(count_reg) : out_count_reg;

        out_valid_next = out_valid_reg;
        if (emit_en)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        pos_reg        <= pos_next;
        hold_reg       <= hold_next;
        res_reg        <= res_next;
        st_reg         <= st_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_value_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.count        = out_count_reg;

    // checks
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) ||
             count_reg == $past(count_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr |-> (CW'(ptr_reg) <= count_reg))
        else $error("RAM write beyond end of list");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.result_value == '0))
        else $error("nonzero value on error response");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en |-> !(out_valid_reg && !rsp.ready))
        else $error("response overwritten while stalled");

endmodule

// File: rtl/alid_seq.sv
// ----------------------------------------------------------------------------
// alid_seq
// Microcode sequencer: step counter, control ROM and jump condition select.
// ----------------------------------------------------------------------------
module alid_seq
    import alid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  alid_flags_t flags,
    input  step_t       dispatch_step,
    output seq_out_t    ctl
);

    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t cw;
    logic       take;

    assign cw = ucode(step_reg);

    always_comb
    begin
        case (cw.cond)
            COND_NONE:       take = 1'b0;
            COND_DISPATCH:   take = flags.in_valid;
            COND_PTR_EQ_POS: take = flags.ptr_eq_pos;
            COND_PTR_LAST:   take = flags.ptr_last;
            COND_OUT_BUSY:   take = flags.out_busy;
            default:         take = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        if (!take)
            step_next = cw.next;
        else if (cw.cond == COND_DISPATCH)
            step_next = dispatch_step;
        else
            step_next = cw.jump;
    end

    // outputs
    always_comb
    begin
        ctl.cw  = cw;
        ctl.run = !take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// File: bench/tb_array_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// tb_array_list_insert_delete_unit
// Self-checking bench for the positional array list unit. A directed table
// covers the empty list, the position errors and the value extremes. Random
// fill, drain and mixed phases follow, with the list taken to full and back
// to empty several times. A shadow copy of the list predicts each response
// word that the table does not give, and the bench compares each one in order
// under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_array_list_insert_delete_unit;
    import alid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP       = ALID_CAPACITY;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int DIR_ROWS       = 25;
    localparam int RAND_ITEMS     = 1525;
    localparam int QUIET_ITEMS    = 150;
    localparam int SETTLE_CYCLES  = LIST_CAP + 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
        logic [COUNT_W-1:0]        count;
    } list_rsp_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] val;
        logic                      typed;
        logic signed [VALUE_W-1:0] exp_value;
        status_t                   exp_status;
        logic [COUNT_W-1:0]        exp_count;
    } dir_row_t;

    typedef enum {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIXED
    } gen_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    alid_cmd_if cmd_if ();
    alid_rsp_if rsp_if ();

    array_list_insert_delete_unit #(
        .CAPACITY (LIST_CAP)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // shadow copy of the list
    logic signed [VALUE_W-1:0] shadow_list [LIST_CAP];
    int unsigned               shadow_len;

    list_rsp_t   expected_q [$];
    dir_row_t    dir_tab [DIR_ROWS];
    int          fail_count;
    int          resp_seen;
    int          cmd_hits [8];
    int          status_hits [4];
    int          full_visits;
    int          empty_visits;
    bit          quiet;
    int          stall_left;
    int          idle_cycles;

    function automatic logic signed [VALUE_W-1:0] pull_entry(int unsigned at);
        logic signed [VALUE_W-1:0] v;
        int unsigned               i;
        v = shadow_list[at];
        for (i = at; i + 1 < shadow_len; i++)
            shadow_list[i] = shadow_list[i + 1];
        shadow_len--;
        return v;
    endfunction

    function automatic list_rsp_t apply_list_cmd(cmd_t c, logic [POS_W-1:0] p,
                                                 logic signed [VALUE_W-1:0] v);
        list_rsp_t   r;
        int unsigned at;
        int unsigned i;
        r.value  = '0;
        r.status = ST_OK;
        at       = p;
        case (c)
            CMD_APPEND, CMD_INSERT_AT:
            begin
                if (c == CMD_APPEND)
                    at = shadow_len;
                if (shadow_len >= LIST_CAP)
                    r.status = ST_FULL;
                else if (at > shadow_len)
                    r.status = ST_BADPOS;
                else
                begin
                    for (i = shadow_len; i > at; i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[at] = v;
                    shadow_len++;
                    r.value = v;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (at >= shadow_len)
                    r.status = ST_BADPOS;
                else
                    r.value = pull_entry(at);
            end
            CMD_REMOVE_FIRST, CMD_REMOVE_LAST:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = pull_entry(c == CMD_REMOVE_FIRST ? 0 : shadow_len - 1);
            end
            CMD_READ_AT:
            begin
                if (at >= shadow_len)
                    r.status = ST_BADPOS;
                else
                    r.value = shadow_list[at];
            end
            default:
            begin
                if (shadow_len == 0)
                    r.status = ST_EMPTY;
                else
                    r.value = shadow_list[c == CMD_READ_FIRST ? 0 : shadow_len - 1];
            end
        endcase
        r.count = COUNT_W'(shadow_len);
        cmd_hits[c]++;
        status_hits[r.status]++;
        if (shadow_len == LIST_CAP && r.status == ST_FULL)
            full_visits++;
        if (r.status == ST_EMPTY)
            empty_visits++;
        return r;
    endfunction

    // presents one command word and returns once it is taken
    task automatic send_word(cmd_t c, logic [POS_W-1:0] p, logic signed [VALUE_W-1:0] v,
                             logic typed, list_rsp_t typed_rsp);
        list_rsp_t r;
        int        gap;
        r = apply_list_cmd(c, p, v);
        if (typed)
            r = typed_rsp;
        if (!quiet && $urandom_range(0, 99) < 15)
        begin
            cmd_if.valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
        end
        expected_q.push_back(r);
        cmd_if.valid    <= 1'b1;
        cmd_if.command  <= c;
        cmd_if.position <= p;
        cmd_if.value    <= v;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
    endtask

    task automatic wait_list_idle();
        cmd_if.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic pick_random_cmd(gen_mode_t mode, output cmd_t c,
                                   output logic [POS_W-1:0] p,
                                   output logic signed [VALUE_W-1:0] v);
        logic [CMD_W-1:0] raw;
        int unsigned      top;
        int unsigned      roll;
        roll = $urandom_range(0, 99);
        raw  = CMD_W'($urandom_range(0, 7));
        c    = cmd_t'(raw);
        if (mode == MODE_FILL && roll < 70)
            c = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT_AT;
        else if (mode == MODE_DRAIN && roll < 70)
        begin
            case ($urandom_range(0, 2))
                0: c = CMD_REMOVE_AT;
                1: c = CMD_REMOVE_FIRST;
                default: c = CMD_REMOVE_LAST;
            endcase
        end
        v = $urandom;
        // mostly in-range positions, some noise over the whole field
        if (c == CMD_INSERT_AT)
            top = (shadow_len > 127) ? 127 : shadow_len;
        else
            top = (shadow_len == 0) ? 127 : ((shadow_len > 128) ? 127 : shadow_len - 1);
        if ($urandom_range(0, 99) < 15)
            p = POS_W'($urandom_range(0, 127));
        else
            p = POS_W'($urandom_range(0, top));
    endtask

    // response side: checks and random back-pressure
    always @(posedge clk)
    begin
        list_rsp_t got;
        list_rsp_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.value  = rsp_if.result_value;
                got.status = status_t'(rsp_if.status);
                got.count  = rsp_if.count;
                resp_seen++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0t] response word with nothing pending: ", $realtime,
                                 "value %h status %0d count %0d",
                                 got.value, got.status, got.count);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("[%0t] word %0d: ", $realtime, resp_seen,
                                     "got value %h status %0d count %0d, ",
                                     got.value, got.status, got.count,
                                     "want value %h status %0d count %0d",
                                     want.value, want.status, want.count);
                    end
                end
            end
            if (quiet)
                rsp_if.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left   <= stall_left - 1;
            end
            else if ($urandom_range(0, 99) < 12)
            begin
                rsp_if.ready <= 1'b0;
                stall_left   <= $urandom_range(0, 5);
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // stall detector: cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] no word moved for %0d cycles, %0d responses pending",
                         $realtime, WATCHDOG_LIMIT, expected_q.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        list_rsp_t                 typed_rsp;
        cmd_t                      c;
        logic [POS_W-1:0]          p;
        logic signed [VALUE_W-1:0] v;
        gen_mode_t                 mode;
        int                        mixed_left;
        int                        n;

        rst_n           = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.command  = CMD_APPEND;
        cmd_if.position = '0;
        cmd_if.value    = '0;
        rsp_if.ready    = 1'b0;
        shadow_len      = 0;
        fail_count      = 0;
        resp_seen       = 0;
        full_visits     = 0;
        empty_visits    = 0;
        quiet           = 1'b0;
        stall_left      = 0;
        idle_cycles     = 0;
        foreach (cmd_hits[i])
            cmd_hits[i] = 0;
        foreach (status_hits[i])
            status_hits[i] = 0;
        foreach (shadow_list[i])
            shadow_list[i] = '0;

        dir_tab = '{
            // empty list: first/last report empty, out-of-range positional ops report bad position
            '{CMD_READ_FIRST,   7'd0,   32'sd0,        1'b1, 32'sd0,        ST_EMPTY,  8'd0},
            '{CMD_REMOVE_LAST,  7'd0,   32'sd0,        1'b1, 32'sd0,        ST_EMPTY,  8'd0},
            '{CMD_REMOVE_FIRST, 7'd0,   32'sd0,        1'b1, 32'sd0,        ST_EMPTY,  8'd0},
            '{CMD_READ_LAST,    7'd0,   32'sd0,        1'b1, 32'sd0,        ST_EMPTY,  8'd0},
            '{CMD_READ_AT,      7'd0,   32'sd0,        1'b1, 32'sd0,        ST_BADPOS, 8'd0},
            '{CMD_REMOVE_AT,    7'd127, 32'sd0,        1'b1, 32'sd0,        ST_BADPOS, 8'd0},
            '{CMD_INSERT_AT,    7'd1,   32'sd5,        1'b1, 32'sd0,        ST_BADPOS, 8'd0},
            '{CMD_INSERT_AT,    7'd0,   32'h8000_0000, 1'b1, 32'h8000_0000, ST_OK,     8'd1},
            '{CMD_APPEND,       7'd99,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_OK,     8'd2},
            // insert at the end position acts as append
            '{CMD_INSERT_AT,    7'd2,   -32'sd1,       1'b1, -32'sd1,       ST_OK,     8'd3},
            '{CMD_INSERT_AT,    7'd1,   32'sd0,        1'b1, 32'sd0,        ST_OK,     8'd4},
            '{CMD_INSERT_AT,    7'd127, 32'sd7,        1'b1, 32'sd0,        ST_BADPOS, 8'd4},
            '{CMD_READ_AT,      7'd127, 32'sd0,        1'b1, 32'sd0,        ST_BADPOS, 8'd4},
            '{CMD_READ_AT,      7'd3,   32'h1234_5678, 1'b0, 32'sd0,        ST_OK,     8'd0},
            '{CMD_READ_FIRST,   7'd127, 32'sd0,        1'b0, 32'sd0,        ST_OK,     8'd0},
            '{CMD_READ_LAST,    7'd0,   32'sd0,        1'b0, 32'sd0,        ST_OK,     8'd0},
            '{CMD_REMOVE_AT,    7'd4,   32'sd0,        1'b1, 32'sd0,        ST_BADPOS, 8'd4},
            '{CMD_REMOVE_AT,    7'd1,   32'sd0,        1'b0, 32'sd0,        ST_OK,     8'd0},
            '{CMD_REMOVE_FIRST, 7'd0,   32'sd0,        1'b0, 32'sd0,        ST_OK,     8'd0},
            '{CMD_REMOVE_LAST,  7'd0,   32'sd0,        1'b0, 32'sd0,        ST_OK,     8'd0},
            '{CMD_APPEND,       7'd0,   32'h5555_5555, 1'b0, 32'sd0,        ST_OK,     8'd0},
            '{CMD_REMOVE_AT,    7'd0,   32'sd0,        1'b0, 32'sd0,        ST_OK,     8'd0},
            '{CMD_APPEND,       7'd127, 32'hAAAA_AAAA, 1'b0, 32'sd0,        ST_OK,     8'd0},
            '{CMD_READ_AT,      7'd0,   32'sd0,        1'b0, 32'sd0,        ST_OK,     8'd0},
            '{CMD_REMOVE_AT,    7'd0,   32'sd0,        1'b0, 32'sd0,        ST_OK,     8'd0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            typed_rsp.value  = dir_tab[i].exp_value;
            typed_rsp.status = dir_tab[i].exp_status;
            typed_rsp.count  = dir_tab[i].exp_count;
            send_word(dir_tab[i].cmd, dir_tab[i].pos, dir_tab[i].val,
                      dir_tab[i].typed, typed_rsp);
        end
        wait_list_idle();

        mode       = MODE_FILL;
        mixed_left = 0;
        typed_rsp  = '0;
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            quiet = (n >= RAND_ITEMS - QUIET_ITEMS);
            case (mode)
                MODE_FILL:
                    if (shadow_len == LIST_CAP && $urandom_range(0, 3) == 0)
                        mode = MODE_DRAIN;
                MODE_DRAIN:
                    if (shadow_len == 0 && $urandom_range(0, 2) == 0)
                    begin
                        mode       = MODE_MIXED;
                        mixed_left = 60;
                    end
                default:
                begin
                    mixed_left--;
                    if (mixed_left <= 0)
                        mode = MODE_FILL;
                end
            endcase
            // hold off now and then until the list unit has drained
            if (n == RAND_ITEMS / 2 || (!quiet && $urandom_range(0, 99) == 0))
                wait_list_idle();
            pick_random_cmd(mode, c, p, v);
            send_word(c, p, v, 1'b0, typed_rsp);
        end
        cmd_if.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d words checked; append %0d insert %0d remove-at %0d first %0d last %0d, ",
                 resp_seen, cmd_hits[CMD_APPEND], cmd_hits[CMD_INSERT_AT],
                 cmd_hits[CMD_REMOVE_AT], cmd_hits[CMD_REMOVE_FIRST],
                 cmd_hits[CMD_REMOVE_LAST],
                 "read-at %0d first %0d last %0d",
                 cmd_hits[CMD_READ_AT], cmd_hits[CMD_READ_FIRST], cmd_hits[CMD_READ_LAST]);
        $display("status ok %0d full %0d empty %0d bad-position %0d; ",
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_BADPOS],
                 "full hits %0d, empty hits %0d; %0d mismatches",
                 full_visits, empty_visits, fail_count);
        if (fail_count == 0 && expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
